@@ hdl/rrt_pkg.sv @@
package rrt_pkg;

   // field widths
   localparam int CoordBits  = 8;
   localparam int IdxBits    = 10;
   localparam int StatusBits = 3;
   localparam int StepBits   = 6;
   localparam int GridBits   = 9;
   localparam int MaxNodesDefault = 1024;

   // datapath widths
   localparam int D2Bits   = 2 * CoordBits + 1;
   localparam int Step2Bits = 2 * StepBits;
   localparam int FracBits = 8;
   localparam int NumBits  = CoordBits + StepBits + FracBits;
   localparam int RootBits = D2Bits;
   localparam int RadBits  = 2 * RootBits;
   localparam int SubBits  = RootBits + 3;
   localparam int CntBits  = 5;

   typedef enum logic [StatusBits-1:0] {
      STAT_ADDED   = 3'd0,
      STAT_GOAL    = 3'd1,
      STAT_OUTSIDE = 3'd2,
      STAT_FULL    = 3'd3,
      STAT_DONE    = 3'd4,
      STAT_RESTART = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      REG_START_X = 3'd0,
      REG_START_Y = 3'd1,
      REG_GOAL_X  = 3'd2,
      REG_GOAL_Y  = 3'd3,
      REG_STEP    = 3'd4,
      REG_GRID    = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_CLOSE,
      S_SQRT,
      S_DIVX,
      S_DIVY,
      S_GOAL,
      S_FINISH
   } state_type;

   // squared distance between two grid points
   function automatic logic [D2Bits-1:0] sq_dist(
      input logic [CoordBits-1:0] ax,
      input logic [CoordBits-1:0] ay,
      input logic [CoordBits-1:0] bx,
      input logic [CoordBits-1:0] by
   );
      logic [CoordBits-1:0] adx;
      logic [CoordBits-1:0] ady;
      logic [2*CoordBits-1:0] sx;
      logic [2*CoordBits-1:0] sy;
      adx = (ax >= bx) ? ax - bx : bx - ax;
      ady = (ay >= by) ? ay - by : by - ay;
      sx = adx * adx;
      sy = ady * ady;
      return D2Bits'(sx) + D2Bits'(sy);
   endfunction

endpackage

@@ hdl/rrt_if.sv @@
interface rrt_req_if;
   import rrt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 req_type;
   logic [CoordBits-1:0] sample_x;
   logic [CoordBits-1:0] sample_y;
   modport source(output valid, req_type, sample_x, sample_y, input ready);
   modport sink(input valid, req_type, sample_x, sample_y, output ready);
endinterface

interface rrt_rsp_if;
   import rrt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CoordBits-1:0]  node_x;
   logic [CoordBits-1:0]  node_y;
   logic [IdxBits-1:0]    node_index;
   logic [StatusBits-1:0] status;
   modport source(output valid, node_x, node_y, node_index, status, input ready);
   modport sink(input valid, node_x, node_y, node_index, status, output ready);
endinterface

@@ hdl/rrt_tree_extend.sv @@
// Tree extension engine: a restart word reseeds the node store with the start
// point; an extend word scans every stored node for the one nearest the sample,
// steps toward the sample by step_length (floored square root, then two serial
// divisions), stores the new node and reports whether the goal is reached.
// Restart and rejected words go from idle straight to the finish state. An
// accepted extend scans the nodes through the single read port of the node
// memory, then runs the square root and the two divisions on the one shared
// subtractor and stores the new node. A sample within one step of its nearest
// node skips the square root and the divisions.
// The block takes one word at a time; a finished result waits in the output
// register while the next word is accepted.
module rrt_tree_extend #(
   parameter int MAX_NODES = rrt_pkg::MaxNodesDefault
) (
   input  logic        clock,
   input  logic        reset,
   rrt_req_if.sink     req_ch,
   rrt_rsp_if.source   rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import rrt_pkg::*;

   localparam int AddrBits  = $clog2(MAX_NODES);
   localparam int CountBits = $clog2(MAX_NODES + 1);
   localparam int WordBits  = 2 * CoordBits;
   localparam int ProdBits  = CoordBits + StepBits;

   // configuration
   logic [CoordBits-1:0] start_x_ff, start_y_ff, goal_x_ff, goal_y_ff;
   logic [StepBits-1:0]  step_ff;
   logic [GridBits-1:0]  grid_ff;

   // control
   state_type            state_ff, state_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic                 done_ff, done_in;
   logic                 seeded_ff, seeded_in;
   logic [CountBits-1:0] rd_idx_ff, rd_idx_in;
   logic                 issue_ff, issue_in;
   logic                 pend_ff, pend_in;
   logic [CountBits-1:0] pend_idx_ff, pend_idx_in;
   logic [CntBits-1:0]   cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [CoordBits-1:0]  samp_x_ff, samp_x_in, samp_y_ff, samp_y_in;
   logic [D2Bits-1:0]     best_d2_ff, best_d2_in;
   logic [CoordBits-1:0]  best_x_ff, best_x_in, best_y_ff, best_y_in;
   logic [CoordBits-1:0]  new_x_ff, new_x_in, new_y_ff, new_y_in;
   logic [NumBits-1:0]    numy_ff, numy_in;
   logic                  negx_ff, negx_in, negy_ff, negy_in;
   logic [RootBits-1:0]   root_ff, root_in;
   logic [SubBits-1:0]    rem_ff, rem_in;
   logic [RadBits-1:0]    work_ff, work_in;
   logic [CoordBits-1:0]  res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic [IdxBits-1:0]    res_idx_ff, res_idx_in;
   status_type            res_stat_ff, res_stat_in;
   logic [CoordBits-1:0]  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [IdxBits-1:0]    rsp_idx_ff, rsp_idx_in;
   status_type            rsp_stat_ff, rsp_stat_in;

   // memory port
   logic                mem_we, mem_re;
   logic [AddrBits-1:0] mem_waddr, mem_raddr;
   logic [WordBits-1:0] mem_wdata, mem_rdata;

   // shared subtractor
   logic [SubBits-1:0] sub_a, sub_b, sub_diff;
   logic               sub_ge;

   logic accept;
   logic csr_write;

   assign accept    = req_ch.valid && req_ch.ready;
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   rrt_ram #(
      .Width(WordBits),
      .Depth(MAX_NODES)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // register file writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         goal_x_ff  <= '0;
         goal_y_ff  <= '0;
         step_ff    <= StepBits'(5);
         grid_ff    <= GridBits'(50);
      end else if (csr_write) begin
         case (paddr[4:2])
            REG_START_X: start_x_ff <= pwdata[CoordBits-1:0];
            REG_START_Y: start_y_ff <= pwdata[CoordBits-1:0];
            REG_GOAL_X:  goal_x_ff  <= pwdata[CoordBits-1:0];
            REG_GOAL_Y:  goal_y_ff  <= pwdata[CoordBits-1:0];
            REG_STEP:    step_ff    <= pwdata[StepBits-1:0];
            REG_GRID:    grid_ff    <= pwdata[GridBits-1:0];
            default: ;
         endcase
      end
   end

   // register file reads
   always_comb begin
      unique case (paddr[4:2])
         REG_START_X: prdata = 32'(start_x_ff);
         REG_START_Y: prdata = 32'(start_y_ff);
         REG_GOAL_X:  prdata = 32'(goal_x_ff);
         REG_GOAL_Y:  prdata = 32'(goal_y_ff);
         REG_STEP:    prdata = 32'(step_ff);
         REG_GRID:    prdata = 32'(grid_ff);
         default:     prdata = '0;
      endcase
   end

   // one subtractor serves both the square root and the divisions
   always_comb begin
      if (state_ff == S_SQRT) begin
         sub_a = {rem_ff[SubBits-3:0], work_ff[RadBits-1 -: 2]};
         sub_b = SubBits'({root_ff, 2'b01});
      end else begin
         sub_a = {rem_ff[SubBits-2:0], work_ff[NumBits-1]};
         sub_b = SubBits'(root_ff);
      end
      sub_ge   = sub_a >= sub_b;
      sub_diff = sub_a - sub_b;
   end

   // sequencer and datapath
   always_comb begin
      logic [CoordBits-1:0]  px, py;
      logic [D2Bits-1:0]     d2;
      logic [Step2Bits-1:0]  step2;
      logic [CoordBits-1:0]  adx, ady;
      logic [ProdBits-1:0]   prod_x, prod_y;
      logic [RootBits-1:0]   root_next;
      logic [NumBits-1:0]    quo;
      logic [SubBits-1:0]    rem_last;
      logic [CoordBits-1:0]  delta;
      logic [CoordBits-1:0]  coord;

      state_in     = state_ff;
      count_in     = count_ff;
      done_in      = done_ff;
      seeded_in    = seeded_ff;
      rd_idx_in    = rd_idx_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      samp_x_in    = samp_x_ff;
      samp_y_in    = samp_y_ff;
      best_d2_in   = best_d2_ff;
      best_x_in    = best_x_ff;
      best_y_in    = best_y_ff;
      new_x_in     = new_x_ff;
      new_y_in     = new_y_ff;
      numy_in      = numy_ff;
      negx_in      = negx_ff;
      negy_in      = negy_ff;
      root_in      = root_ff;
      rem_in       = rem_ff;
      work_in      = work_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      res_idx_in   = res_idx_ff;
      res_stat_in  = res_stat_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_stat_in  = rsp_stat_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = {start_x_ff, start_y_ff};
      mem_re       = 1'b0;
      mem_raddr    = rd_idx_ff[AddrBits-1:0];
      req_ch.ready = (state_ff == S_IDLE);

      px        = (pend_idx_ff == '0 && !seeded_ff) ? '0 : mem_rdata[WordBits-1 -: CoordBits];
      py        = (pend_idx_ff == '0 && !seeded_ff) ? '0 : mem_rdata[CoordBits-1:0];
      d2        = sq_dist(px, py, samp_x_ff, samp_y_ff);
      step2     = step_ff * step_ff;
      adx       = (samp_x_ff >= best_x_ff) ? samp_x_ff - best_x_ff : best_x_ff - samp_x_ff;
      ady       = (samp_y_ff >= best_y_ff) ? samp_y_ff - best_y_ff : best_y_ff - samp_y_ff;
      prod_x    = ProdBits'(adx) * ProdBits'(step_ff);
      prod_y    = ProdBits'(ady) * ProdBits'(step_ff);
      root_next = {root_ff[RootBits-2:0], sub_ge};
      quo       = {work_ff[NumBits-2:0], sub_ge};
      rem_last  = sub_ge ? sub_diff : sub_a;
      delta     = quo[CoordBits-1:0] + CoordBits'(negx_ff && rem_last != '0);
      coord     = '0;

      // drop the result once taken
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               samp_x_in  = req_ch.sample_x;
               samp_y_in  = req_ch.sample_y;
               res_x_in   = '0;
               res_y_in   = '0;
               res_idx_in = '0;
               state_in   = S_FINISH;
               if (!req_ch.req_type) begin
                  mem_we      = 1'b1;
                  count_in    = CountBits'(1);
                  done_in     = 1'b0;
                  seeded_in   = 1'b1;
                  res_x_in    = start_x_ff;
                  res_y_in    = start_y_ff;
                  res_stat_in = STAT_RESTART;
               end else if (done_ff) begin
                  res_stat_in = STAT_DONE;
               end else if (GridBits'(req_ch.sample_x) >= grid_ff ||
                            GridBits'(req_ch.sample_y) >= grid_ff) begin
                  res_stat_in = STAT_OUTSIDE;
               end else if (count_ff >= CountBits'(MAX_NODES)) begin
                  res_stat_in = STAT_FULL;
               end else begin
                  rd_idx_in = '0;
                  issue_in  = 1'b1;
                  state_in  = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // issue one read a cycle, compare each word in the cycle after its read
            mem_re      = issue_ff;
            pend_in     = issue_ff;
            pend_idx_in = rd_idx_ff;
            if (issue_ff) begin
               rd_idx_in = rd_idx_ff + 1'b1;
               issue_in  = (rd_idx_ff + 1'b1) < count_ff;
            end
            if (pend_ff) begin
               if (pend_idx_ff == '0 || d2 < best_d2_ff) begin
                  best_d2_in = d2;
                  best_x_in  = px;
                  best_y_in  = py;
               end
               if (pend_idx_ff == count_ff - 1'b1) begin
                  state_in = S_CLOSE;
               end
            end
         end
         S_CLOSE: begin
            negx_in = samp_x_ff < best_x_ff;
            negy_in = samp_y_ff < best_y_ff;
            work_in = RadBits'({prod_x, FracBits'(0)});
            numy_in = {prod_y, FracBits'(0)};
            if (D2Bits'(best_d2_ff) < D2Bits'(step2) || best_d2_ff == '0) begin
               new_x_in = samp_x_ff;
               new_y_in = samp_y_ff;
               state_in = S_GOAL;
            end else begin
               // radicand is the squared distance with 16 fraction bits
               work_in  = {1'b0, best_d2_ff, 16'b0};
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            rem_in  = sub_ge ? sub_diff : sub_a;
            root_in = root_next;
            work_in = {work_ff[RadBits-3:0], 2'b00};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CntBits'(RootBits - 1)) begin
               root_in  = (root_next == '0) ? RootBits'(1) : root_next;
               work_in  = RadBits'({prod_x, FracBits'(0)});
               rem_in   = '0;
               cnt_in   = '0;
               state_in = S_DIVX;
            end
         end
         S_DIVX, S_DIVY: begin
            rem_in  = rem_last;
            work_in = RadBits'(quo);
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CntBits'(NumBits - 1)) begin
               if (state_ff == S_DIVX) begin
                  coord    = negx_ff ? best_x_ff - delta : best_x_ff + quo[CoordBits-1:0];
                  new_x_in = coord;
                  negx_in  = negy_ff;
                  work_in  = RadBits'(numy_ff);
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = S_DIVY;
               end else begin
                  coord    = negx_ff ? best_y_ff - delta : best_y_ff + quo[CoordBits-1:0];
                  new_y_in = coord;
                  state_in = S_GOAL;
               end
            end
         end
         S_GOAL: begin
            mem_we      = 1'b1;
            mem_waddr   = count_ff[AddrBits-1:0];
            mem_wdata   = {new_x_ff, new_y_ff};
            count_in    = count_ff + 1'b1;
            res_x_in    = new_x_ff;
            res_y_in    = new_y_ff;
            res_idx_in  = IdxBits'(count_ff);
            res_stat_in = STAT_ADDED;
            if (sq_dist(new_x_ff, new_y_ff, goal_x_ff, goal_y_ff) < D2Bits'(step2)) begin
               done_in     = 1'b1;
               res_stat_in = STAT_GOAL;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = res_x_ff;
               rsp_y_in     = res_y_ff;
               rsp_idx_in   = res_idx_ff;
               rsp_stat_in  = res_stat_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= CountBits'(1);
         done_ff      <= 1'b0;
         seeded_ff    <= 1'b0;
         issue_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         done_ff      <= done_in;
         seeded_ff    <= seeded_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      pend_idx_ff <= pend_idx_in;
      cnt_ff      <= cnt_in;
      samp_x_ff   <= samp_x_in;
      samp_y_ff   <= samp_y_in;
      best_d2_ff  <= best_d2_in;
      best_x_ff   <= best_x_in;
      best_y_ff   <= best_y_in;
      new_x_ff    <= new_x_in;
      new_y_ff    <= new_y_in;
      numy_ff     <= numy_in;
      negx_ff     <= negx_in;
      negy_ff     <= negy_in;
      root_ff     <= root_in;
      rem_ff      <= rem_in;
      work_ff     <= work_in;
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
      res_idx_ff  <= res_idx_in;
      res_stat_ff <= res_stat_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.node_x     = rsp_x_ff;
   assign rsp_ch.node_y     = rsp_y_ff;
   assign rsp_ch.node_index = rsp_idx_ff;
   assign rsp_ch.status     = rsp_stat_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CountBits'(1) && count_ff <= CountBits'(MAX_NODES))
      else $error("node count out of range");

   a_no_store_after_goal: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_GOAL |-> !done_ff)
      else $error("node stored after goal reached");

   a_restart_seeds: assert property (@(posedge clock) disable iff (reset)
      accept && !req_ch.req_type |=> count_ff == CountBits'(1) && !done_ff)
      else $error("restart did not reseed the tree");
`endif
endmodule

@@ hdl/rrt_ram.sv @@
module rrt_ram #(
   parameter int Width = 16,
   parameter int Depth = 1024,
   localparam int AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic                clock,
   input  logic                we,
   input  logic [AddrBits-1:0] waddr,
   input  logic [Width-1:0]    wdata,
   input  logic                re,
   input  logic [AddrBits-1:0] raddr,
   output logic [Width-1:0]    rdata
);
   logic [Width-1:0] mem [Depth];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule
